/* hdl/slle_pkg.sv */
// ============================================================================
// slle_pkg: shared definitions for the serial login line editor
// character codes, phase codes, event codes, register map and helpers
// ============================================================================
package slle_pkg;

    localparam int LineCharsDefault = 15;

    localparam logic [7:0] ChBs    = 8'h08;
    localparam logic [7:0] ChDel   = 8'h7F;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSp    = 8'h20;
    localparam logic [7:0] ChMask  = 8'h2A;
    localparam logic [7:0] PrintLo = 8'd32;
    localparam logic [7:0] PrintHi = 8'd126;

    localparam logic [1:0] PH_USER = 2'd0;
    localparam logic [1:0] PH_PASS = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_USER = 2'd1;
    localparam logic [1:0] EV_OK   = 2'd2;
    localparam logic [1:0] EV_FAIL = 2'd3;

    localparam int AddrWidth = 6;
    localparam int DataWidth = 64;

    localparam logic [2:0] REG_USER_LOW  = 3'd0;
    localparam logic [2:0] REG_USER_HIGH = 3'd1;
    localparam logic [2:0] REG_USER_LEN  = 3'd2;
    localparam logic [2:0] REG_PASS_LOW  = 3'd3;
    localparam logic [2:0] REG_PASS_HIGH = 3'd4;
    localparam logic [2:0] REG_PASS_LEN  = 3'd5;

    typedef logic [7:0] char_t;
    typedef logic [3:0] count_t;

    // expected character at a fixed position of the configured text
    function automatic char_t expected_char(logic [63:0] lo, logic [63:0] hi, int idx);
        logic [63:0] sel;
        sel = (idx < 8) ? lo : hi;
        return sel[8 * (idx & 7) +: 8];
    endfunction

endpackage

/* hdl/serial_login_line_editor.sv */
// a received byte waits in the input register until the result register is free,
// then its results are loaded there; throughput: one byte per cycle while each
// byte gives at most one result and tx_stall is low; the three-entry result
// register drains one per accepted output (erase gives three, carriage return two)
// reset: asynchronous, active low; control registers clear to zero, username entry
// starts; data registers are not reset
// ============================================================================
// serial_login_line_editor: login line editor on received serial bytes
// username entry then password entry with echo, erase and exact credential check
// ============================================================================
module serial_login_line_editor
#(
    parameter int LINE_CHARS = slle_pkg::LineCharsDefault
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rx_valid,
    output logic                           rx_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           tx_valid,
    input  logic                           tx_stall,
    output logic [7:0]                     tx_byte,
    output logic                           last,
    output logic [1:0]                     event_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slle_pkg::AddrWidth-1:0] paddr,
    input  logic [slle_pkg::DataWidth-1:0] pwdata,
    output logic [slle_pkg::DataWidth-1:0] prdata,
    output logic                           pready
);
    import slle_pkg::*;

    localparam count_t LineMax = count_t'(LINE_CHARS);

    logic [63:0] user_low_reg, user_high_reg, pass_low_reg, pass_high_reg;
    count_t      user_len_reg, pass_len_reg;

    logic        in_valid_reg;
    char_t       in_byte_reg;

    logic [1:0]  phase_reg, phase_next;
    count_t      char_count_reg, char_count_next;
    count_t      user_count_reg, user_count_next;
    char_t       user_line_reg [LINE_CHARS];
    char_t       pass_line_reg [LINE_CHARS];

    char_t       res_byte_reg [3];
    logic [1:0]  res_left_reg;
    logic [1:0]  res_event_reg;

    logic        cfg_write;
    logic        out_accept;
    logic        buf_free;
    logic        fire;
    logic [1:0]  n_res;
    char_t       b0, b1, b2;
    logic [1:0]  ev;
    logic        wr_en;
    logic        wr_user;
    logic        user_match;
    logic        pass_match;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[5:3])
            REG_USER_LOW:  prdata = user_low_reg;
            REG_USER_HIGH: prdata = user_high_reg;
            REG_USER_LEN:  prdata = {60'd0, user_len_reg};
            REG_PASS_LOW:  prdata = pass_low_reg;
            REG_PASS_HIGH: prdata = pass_high_reg;
            REG_PASS_LEN:  prdata = {60'd0, pass_len_reg};
            default:       prdata = '0;
        endcase
    end

    // handshake
    assign out_accept = tx_valid && !tx_stall;
    assign buf_free   = (res_left_reg == 2'd0) || ((res_left_reg == 2'd1) && out_accept);
    assign fire       = in_valid_reg && buf_free;
    assign rx_stall   = in_valid_reg && !fire;

    assign tx_valid  = (res_left_reg != 2'd0);
    assign tx_byte   = res_byte_reg[0];
    assign last      = (res_left_reg == 2'd1);
    assign event_res = (res_left_reg == 2'd1) ? res_event_reg : EV_NONE;

    // credential compare
    always_comb
    begin
        user_match = (user_count_reg == user_len_reg) && (user_count_reg <= LineMax);
        pass_match = (char_count_reg == pass_len_reg) && (char_count_reg <= LineMax);
        for (int i = 0; i < LINE_CHARS; i++)
        begin
            if ((count_t'(i) < user_count_reg) &&
                (user_line_reg[i] != expected_char(user_low_reg, user_high_reg, i)))
            begin
                user_match = 1'b0;
            end
            if ((count_t'(i) < char_count_reg) &&
                (pass_line_reg[i] != expected_char(pass_low_reg, pass_high_reg, i)))
            begin
                pass_match = 1'b0;
            end
        end
    end

    // line editing
    always_comb
    begin
        phase_next      = phase_reg;
        char_count_next = char_count_reg;
        user_count_next = user_count_reg;
        n_res           = 2'd0;
        b0              = ChBs;
        b1              = ChSp;
        b2              = ChBs;
        ev              = EV_NONE;
        wr_en           = 1'b0;
        wr_user         = (phase_reg == PH_USER);
        if ((phase_reg == PH_USER) || (phase_reg == PH_PASS))
        begin
            if ((in_byte_reg == ChBs) || (in_byte_reg == ChDel))
            begin
                if (char_count_reg != 4'd0)
                begin
                    char_count_next = char_count_reg - 4'd1;
                    n_res           = 2'd3;
                end
            end
            else if (in_byte_reg == ChCr)
            begin
                n_res = 2'd2;
                b0    = ChLf;
                b1    = ChCr;
                if (phase_reg == PH_USER)
                begin
                    user_count_next = char_count_reg;
                    phase_next      = PH_PASS;
                    ev              = EV_USER;
                end
                else
                begin
                    user_count_next = 4'd0;
                    if (user_match && pass_match)
                    begin
                        phase_next = PH_DONE;
                        ev         = EV_OK;
                    end
                    else
                    begin
                        phase_next = PH_USER;
                        ev         = EV_FAIL;
                    end
                end
                char_count_next = 4'd0;
            end
            else if ((in_byte_reg inside {[PrintLo:PrintHi]}) && (char_count_reg < LineMax))
            begin
                wr_en           = 1'b1;
                char_count_next = char_count_reg + 4'd1;
                n_res           = 2'd1;
                b0              = (phase_reg == PH_USER) ? in_byte_reg : ChMask;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_low_reg   <= '0;
            user_high_reg  <= '0;
            user_len_reg   <= '0;
            pass_low_reg   <= '0;
            pass_high_reg  <= '0;
            pass_len_reg   <= '0;
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_USER;
            char_count_reg <= '0;
            user_count_reg <= '0;
            res_left_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[5:3])
                    REG_USER_LOW:  user_low_reg  <= pwdata;
                    REG_USER_HIGH: user_high_reg <= pwdata;
                    REG_USER_LEN:  user_len_reg  <= pwdata[3:0];
                    REG_PASS_LOW:  pass_low_reg  <= pwdata;
                    REG_PASS_HIGH: pass_high_reg <= pwdata;
                    REG_PASS_LEN:  pass_len_reg  <= pwdata[3:0];
                    default:       ;
                endcase
            end
            if (rx_valid && !rx_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg      <= phase_next;
                char_count_reg <= char_count_next;
                user_count_reg <= user_count_next;
                res_left_reg   <= n_res;
            end
            else if (out_accept)
            begin
                res_left_reg <= res_left_reg - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire)
        begin
            res_byte_reg[0] <= b0;
            res_byte_reg[1] <= b1;
            res_byte_reg[2] <= b2;
            res_event_reg   <= ev;
        end
        else if (out_accept)
        begin
            res_byte_reg[0] <= res_byte_reg[1];
            res_byte_reg[1] <= res_byte_reg[2];
        end
        for (int i = 0; i < LINE_CHARS; i++)
        begin
            if (fire && wr_en && (char_count_reg == count_t'(i)))
            begin
                if (wr_user)
                begin
                    user_line_reg[i] <= in_byte_reg;
                end
                else
                begin
                    pass_line_reg[i] <= in_byte_reg;
                end
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= LineMax)
        else $error("line count beyond buffer size");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (res_left_reg == 2'd0) || (res_left_reg == 2'd1 && out_accept))
        else $error("result register overwritten");

    a_event_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (event_res != EV_NONE) |-> last)
        else $error("event on a non-final result");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("accepted login left");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending input lost");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: serial login line editor
// drives received bytes through a valid/stall channel with random gaps, keeps
// its own line-editing and credential-check predictor, and compares every
// transmitted transaction field by field against the oldest expected result;
// credentials are changed over the APB port between idle phases
// ============================================================================
module testbench;

    import slle_pkg::*;

    localparam int LineMax = LineCharsDefault;

    typedef char_t line_t [LineMax];

    typedef struct packed {
        char_t      tx;
        logic       last;
        logic [1:0] ev;
    } echo_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 rx_valid = 1'b0;
    logic                 rx_stall;
    logic [7:0]           rx_byte = '0;
    logic                 tx_valid;
    logic                 tx_stall = 1'b0;
    logic [7:0]           tx_byte;
    logic                 last;
    logic [1:0]           event_res;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [DataWidth-1:0] pwdata = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    serial_login_line_editor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_byte   (tx_byte),
        .last      (last),
        .event_res (event_res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // credential mirror and editor state
    logic [63:0] want_user_lo = '0;
    logic [63:0] want_user_hi = '0;
    count_t      want_user_len = '0;
    logic [63:0] want_pass_lo = '0;
    logic [63:0] want_pass_hi = '0;
    count_t      want_pass_len = '0;

    logic [1:0] login_phase = PH_USER;
    count_t     line_len = '0;
    count_t     user_len = '0;
    line_t      user_chars;
    line_t      pass_chars;

    char_t pending [$];
    echo_t echo_due [$];
    echo_t due_echo;
    int    bytes_queued = 0;
    int    bytes_taken = 0;
    int    echoes_seen = 0;
    int    error_count = 0;
    int    rx_gap = 0;
    int    stall_left = 0;
    bit    rx_quiet = 1'b0;
    bit    tx_quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_echo(input char_t tx, input logic lst, input logic [1:0] ev);
        echo_t e;
        e.tx = tx;
        e.last = lst;
        e.ev = ev;
        echo_due.push_back(e);
    endtask

    function automatic bit line_equals(input line_t chars, input count_t n,
                                       input logic [63:0] lo, input logic [63:0] hi,
                                       input count_t want_len);
        logic [127:0] text;
        text = {hi, lo};
        if (n != want_len)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (chars[i] != text[8 * i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // line editor predictor: one received byte in, expected transmit bytes out
    task automatic take_byte(input char_t b);
        logic [1:0] ev;
        if (login_phase != PH_USER && login_phase != PH_PASS)
            return;
        if (b == ChBs || b == ChDel)
        begin
            if (line_len != 0)
            begin
                line_len--;
                queue_echo(ChBs, 1'b0, EV_NONE);
                queue_echo(ChSp, 1'b0, EV_NONE);
                queue_echo(ChBs, 1'b1, EV_NONE);
            end
        end
        else if (b == ChCr)
        begin
            if (login_phase == PH_USER)
            begin
                user_len = line_len;
                login_phase = PH_PASS;
                ev = EV_USER;
            end
            else
            begin
                if (line_equals(user_chars, user_len, want_user_lo, want_user_hi,
                                want_user_len) &&
                    line_equals(pass_chars, line_len, want_pass_lo, want_pass_hi,
                                want_pass_len))
                begin
                    login_phase = PH_DONE;
                    ev = EV_OK;
                end
                else
                begin
                    login_phase = PH_USER;
                    ev = EV_FAIL;
                end
                user_len = '0;
            end
            line_len = '0;
            queue_echo(ChLf, 1'b0, EV_NONE);
            queue_echo(ChCr, 1'b1, ev);
        end
        else if (b >= PrintLo && b <= PrintHi && line_len < LineMax)
        begin
            if (login_phase == PH_USER)
                user_chars[line_len] = b;
            else
                pass_chars[line_len] = b;
            line_len++;
            queue_echo((login_phase == PH_USER) ? b : ChMask, 1'b1, EV_NONE);
        end
    endtask

    // rx side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte <= '0;
            rx_gap = 0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
            begin
                take_byte(rx_byte);
                bytes_taken++;
                if (bytes_taken % 48 == 0)
                    rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!rx_valid || !rx_stall)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    rx_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    rx_byte <= pending.pop_front();
                    rx_valid <= 1'b1;
                    rx_gap = rx_quiet ? 0 : idle_length();
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // tx side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (tx_valid && !tx_stall)
            begin
                if (echo_due.size() == 0)
                    report($sformatf("unexpected transaction: tx_byte %h last %b event %0d",
                                     tx_byte, last, event_res));
                else
                begin
                    due_echo = echo_due.pop_front();
                    if (tx_byte !== due_echo.tx || last !== due_echo.last ||
                        event_res !== due_echo.ev)
                        report($sformatf({"transaction mismatch: tx_byte %h/%h last %b/%b",
                                          " event %0d/%0d (got/expected)"},
                                         tx_byte, due_echo.tx, last, due_echo.last,
                                         event_res, due_echo.ev));
                    echoes_seen++;
                    if (echoes_seen % 60 == 0)
                        tx_quiet = ($urandom_range(0, 3) == 0);
                end
            end
            if (stall_left > 0)
            begin
                tx_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                tx_stall <= 1'b0;
                if (!tx_quiet && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    task automatic push(input char_t b);
        pending.push_back(b);
        bytes_queued++;
    endtask

    function automatic char_t ignored_byte();
        char_t b;
        if ($urandom_range(0, 1) == 0)
            return char_t'($urandom_range(128, 255));
        b = char_t'($urandom_range(0, 31));
        while (b == ChBs || b == ChCr)
            b = char_t'($urandom_range(0, 31));
        return b;
    endfunction

    function automatic char_t erase_byte();
        return ($urandom_range(0, 1) == 0) ? ChBs : ChDel;
    endfunction

    function automatic logic [63:0] printable_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8 * i +: 8] = char_t'($urandom_range(32, 126));
        return w;
    endfunction

    task automatic drain();
        while (bytes_taken != bytes_queued || echo_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_USER_LOW:  want_user_lo = val;
            REG_USER_HIGH: want_user_hi = val;
            REG_USER_LEN:  want_user_len = val[3:0];
            REG_PASS_LOW:  want_pass_lo = val;
            REG_PASS_HIGH: want_pass_hi = val;
            REG_PASS_LEN:  want_pass_len = val[3:0];
            default: ;
        endcase
    endtask

    task automatic load_credentials(input logic [63:0] ulo, input logic [63:0] uhi,
                                    input logic [63:0] ulen, input logic [63:0] plo,
                                    input logic [63:0] phi, input logic [63:0] plen);
        write_reg(REG_USER_LOW, ulo);
        write_reg(REG_USER_HIGH, uhi);
        write_reg(REG_USER_LEN, ulen);
        write_reg(REG_PASS_LOW, plo);
        write_reg(REG_PASS_HIGH, phi);
        write_reg(REG_PASS_LEN, plen);
    endtask

    // typable version of a configured text; untypable characters get replaced
    task automatic typable(input logic [63:0] lo, input logic [63:0] hi,
                           input count_t len, output line_t s, output int n);
        logic [127:0] text;
        char_t        c;
        text = {hi, lo};
        n = len;
        for (int i = 0; i < LineMax; i++)
        begin
            c = text[8 * i +: 8];
            if (c < PrintLo || c > PrintHi)
                c = char_t'($urandom_range(32, 126));
            s[i] = c;
        end
    endtask

    // make the line differ from the target in length or in one character
    task automatic spoil(inout line_t s, inout int n);
        int    pos;
        char_t c;
        if ($urandom_range(0, 1) == 0 || n == 0)
        begin
            if (n < LineMax && ($urandom_range(0, 1) == 0 || n == 0))
            begin
                s[n] = char_t'($urandom_range(32, 126));
                n++;
            end
            else
                n--;
        end
        else
        begin
            pos = $urandom_range(0, n - 1);
            c = char_t'($urandom_range(32, 126));
            while (c == s[pos])
                c = char_t'($urandom_range(32, 126));
            s[pos] = c;
        end
    endtask

    task automatic type_line(input line_t s, input int n);
        int r;
        if ($urandom_range(0, 9) == 0)
            push(erase_byte());
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                push(char_t'($urandom_range(32, 126)));
                push(erase_byte());
            end
            else if (r < 22)
                push(ignored_byte());
            push(s[i]);
        end
        if (n == LineMax && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push(char_t'($urandom_range(32, 126)));
    endtask

    task automatic random_attempts(input int count);
        line_t user_try;
        line_t pass_try;
        int    user_n;
        int    pass_n;
        int    start;
        int    r;
        start = bytes_queued;
        while (bytes_queued - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                typable(want_user_lo, want_user_hi, want_user_len, user_try, user_n);
                typable(want_pass_lo, want_pass_hi, want_pass_len, pass_try, pass_n);
                case ($urandom_range(0, 2))
                    0: spoil(user_try, user_n);
                    1: spoil(pass_try, pass_n);
                    default:
                    begin
                        spoil(user_try, user_n);
                        spoil(pass_try, pass_n);
                    end
                endcase
                type_line(user_try, user_n);
                push(ChCr);
                type_line(pass_try, pass_n);
                push(ChCr);
            end
            else if (r < 85)
            begin
                for (int i = 0; i < LineMax; i++)
                    user_try[i] = char_t'($urandom_range(32, 126));
                type_line(user_try, $urandom_range(0, LineMax));
                push(ChCr);
            end
            else
            begin
                repeat ($urandom_range(3, 10))
                begin
                    r = $urandom_range(0, 255);
                    push((char_t'(r) == ChCr) ? ChDel : char_t'(r));
                end
            end
        end
    endtask

    initial
    begin
        line_t user_try;
        line_t pass_try;
        int    user_n;
        int    pass_n;

        for (int i = 0; i < LineMax; i++)
        begin
            user_chars[i] = '0;
            pass_chars[i] = '0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset credentials: ignored bytes, erase on empty, range edges, full line
        push(8'h00);
        push(ChBs);
        push(ChDel);
        push(8'd31);
        push(8'd128);
        push(8'hFF);
        push(PrintLo);
        push(PrintHi);
        repeat (13) push(8'h41);
        push(PrintHi);
        push(8'h7A);
        push(ChDel);
        push(ChBs);
        push(ChCr);
        push(8'h70);
        push(ChBs);
        push(ChCr);
        drain();

        // every register at its all-ones value
        load_credentials('1, '1, '1, '1, '1, '1);
        random_attempts(40);
        drain();

        // zero text with a nonzero username length can never match
        load_credentials('0, '0, 64'd3, '0, '0, 64'd0);
        random_attempts(40);
        drain();

        load_credentials(printable_word(), printable_word(), 64'd0,
                         printable_word(), printable_word(), 64'd15);
        random_attempts(40);
        drain();

        load_credentials(printable_word(), printable_word(), 64'd15,
                         printable_word(), printable_word(), 64'($urandom_range(1, 14)));
        random_attempts(40);
        drain();

        repeat (2)
        begin
            load_credentials(printable_word(), printable_word(),
                             64'($urandom_range(1, 15)), printable_word(),
                             printable_word(), 64'($urandom_range(0, 15)));
            random_attempts(40);
            drain();
        end

        // a correct login, after which the block ignores everything
        load_credentials(printable_word(), printable_word(), 64'd15,
                         printable_word(), printable_word(), 64'($urandom_range(0, 15)));
        if (login_phase == PH_PASS)
        begin
            push(ChCr);
            drain();
        end
        repeat (line_len) push(erase_byte());
        typable(want_user_lo, want_user_hi, want_user_len, user_try, user_n);
        typable(want_pass_lo, want_pass_hi, want_pass_len, pass_try, pass_n);
        type_line(user_try, user_n);
        push(ChCr);
        type_line(pass_try, pass_n);
        push(ChCr);
        push(ChCr);
        push(ChBs);
        repeat (8) push(char_t'($urandom_range(0, 255)));
        drain();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
hdl/slle_pkg.sv
hdl/serial_login_line_editor.sv
tb/testbench.sv
